// File: rtl/core/ppln_pkg.sv
// shared types and constants of the per-pixel layer norm block
package ppln_pkg;

  localparam int unsigned DivW      = 38;  // dividend / radicand field of the shared unit
  localparam int unsigned DenW      = 17;  // divisor width
  localparam int unsigned RemW      = 21;  // partial remainder width
  localparam int unsigned DivSteps  = 38;  // one quotient bit a step
  localparam int unsigned SqrtSteps = 17;  // one root bit a step

  localparam logic REQ_LOAD   = 1'b0;
  localparam logic REQ_SAMPLE = 1'b1;

  localparam logic CFG_CHAN_NUM = 1'b0;
  localparam logic CFG_EPSILON  = 1'b1;

  typedef struct packed {
    logic               req_type;
    logic [5:0]         channel_index;
    logic signed [15:0] sample_value;
    logic signed [15:0] scale_word;
    logic signed [15:0] offset_word;
  } ppln_in_t;

  typedef struct packed {
    logic signed [15:0] norm_value;
    logic               last_of_pixel;
  } ppln_out_t;

  typedef struct packed {
    logic start;
    logic is_sqrt;
  } iu_req_t;

endpackage

// File: rtl/core/ppln_iter.sv
// shared iterative unit: restoring divide or digit-by-digit square root
module ppln_iter import ppln_pkg::*; (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  iu_req_t         req_i,
  input  logic [DivW-1:0] opa_i,
  input  logic [DenW-1:0] opb_i,
  output logic            done_o,
  output logic [DivW-1:0] res_o
);

  logic            busy_q, sqrt_q, done_q;
  logic [5:0]      cnt_q;
  logic [DivW-1:0] num_q, quo_q;
  logic [DenW-1:0] den_q;
  logic [RemW-1:0] rem_q;

  logic [RemW-1:0] rem_sh, trial, rem_nx;
  logic            ge, last;

  always_comb begin
    if (sqrt_q) begin
      rem_sh = {rem_q[RemW-3:0], num_q[DivW-1 -: 2]};
      trial  = {2'b00, quo_q[DenW-1:0], 2'b01};
    end else begin
      rem_sh = {rem_q[RemW-2:0], num_q[DivW-1]};
      trial  = {{(RemW-DenW){1'b0}}, den_q};
    end
    ge     = rem_sh >= trial;
    rem_nx = ge ? rem_sh - trial : rem_sh;
    last   = cnt_q == (sqrt_q ? 6'(SqrtSteps - 1) : 6'(DivSteps - 1));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      sqrt_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start) begin
        busy_q <= 1'b1;
        sqrt_q <= req_i.is_sqrt;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 6'd1;
        if (last) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      num_q <= opa_i;
      den_q <= opb_i;
      rem_q <= '0;
      quo_q <= '0;
    end else if (busy_q) begin
      num_q <= sqrt_q ? {num_q[DivW-3:0], 2'b00} : {num_q[DivW-2:0], 1'b0};
      rem_q <= rem_nx;
      quo_q <= {quo_q[DivW-2:0], ge};
    end
  end

  assign done_o = done_q;
  assign res_o  = quo_q;

endmodule

// File: rtl/core/per_pixel_layer_norm.sv
// per-pixel layer norm: top level with sequencer, pixel store and tables
// sequence: a load or a non-final sample is taken while idle; the final sample of a pixel of n channels
//   starts the work: sum pass, mean divide, variance pass,
//   variance divide, root, reciprocal divide and an output pass with one result per channel
// throughput: one pixel at a time, set by the single shared divide/root unit and the store port
// reset: asynchronous active low; channel number 64, epsilon 1, scale 1.0, offset 0,
//   pixel store contents undefined until written
module per_pixel_layer_norm import ppln_pkg::*; #(
  parameter int unsigned MAX_CHANNELS = 64
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  ppln_in_t    in_data_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output ppln_out_t   out_data_o,
  input  logic        cfg_we_i,
  input  logic        cfg_idx_i,
  input  logic [15:0] cfg_wdata_i
);

  localparam int unsigned IdxW  = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
  localparam logic [6:0]  MaxCh = 7'(MAX_CHANNELS);

  // sequencer codes
  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_SUM  = 3'd1;
  localparam logic [2:0] S_MEAN = 3'd2;
  localparam logic [2:0] S_VAR  = 3'd3;
  localparam logic [2:0] S_VDIV = 3'd4;
  localparam logic [2:0] S_SQRT = 3'd5;
  localparam logic [2:0] S_INV  = 3'd6;
  localparam logic [2:0] S_OUT  = 3'd7;

  logic [2:0]  state_q, state_d;
  logic [6:0]  cc_q, fill_q, idx_q, n_act;
  logic [15:0] eps_q;
  logic [1:0]  ph_q;
  logic        rv_q, sv_q, launch_q;

  logic signed [21:0] sum_q;
  logic        [21:0] sum_abs;
  logic        [37:0] sq_q;
  logic        [31:0] prod_q;
  logic signed [16:0] mean_q;
  logic        [33:0] rad_q;
  logic        [16:0] s_q;
  logic        [24:0] inv_q;
  logic signed [43:0] p1_q, p2_q;
  logic signed [15:0] sc_q, of_q;

  logic        out_valid_q;
  ppln_out_t   out_q;

  // storage
  logic [15:0] smem   [MAX_CHANNELS];
  logic [15:0] scmem  [MAX_CHANNELS];
  logic [15:0] ofmem  [MAX_CHANNELS];
  logic [MAX_CHANNELS-1:0] tvld_q;
  logic [15:0] smem_q, scmem_q, ofmem_q;
  logic        tvld_rd_q;

  logic        in_acc, ld_acc, smp_acc, issue, pix_done;
  logic [IdxW-1:0] rd_addr;

  iu_req_t         iu_req;
  logic [DivW-1:0] iu_opa, iu_res;
  logic [DenW-1:0] iu_opb;
  logic            iu_done;

  logic signed [17:0] d;
  logic signed [35:0] dd;
  logic        [16:0] mag;
  logic signed [32:0] v;
  logic signed [15:0] sat;

  // effective channel count: zero acts as one, overlarge clamps
  always_comb begin
    if (cc_q == 7'd0) n_act = 7'd1;
    else if (cc_q > MaxCh) n_act = MaxCh;
    else n_act = cc_q;
  end

  assign in_ready_o = state_q == S_IDLE;
  assign in_acc     = in_valid_i && in_ready_o;
  assign ld_acc     = in_acc && (in_data_i.req_type == REQ_LOAD);
  assign smp_acc    = in_acc && (in_data_i.req_type == REQ_SAMPLE);
  assign pix_done   = (fill_q + 7'd1) >= n_act;
  assign rd_addr    = idx_q[IdxW-1:0];
  assign issue      = ((state_q == S_SUM || state_q == S_VAR) && idx_q < n_act) ||
                      (state_q == S_OUT && ph_q == 2'd0);
  // magnitude of the sum, the most negative sum included
  assign sum_abs    = sum_q[21] ? 22'(-sum_q) : 22'(sum_q);

  // memory ports: one write, one registered read each
  always_ff @(posedge clk_i) begin
    if (smp_acc) smem[fill_q[IdxW-1:0]] <= in_data_i.sample_value;
    smem_q <= smem[rd_addr];
  end

  always_ff @(posedge clk_i) begin
    if (ld_acc && ({1'b0, in_data_i.channel_index} < MaxCh)) begin
      scmem[in_data_i.channel_index[IdxW-1:0]] <= in_data_i.scale_word;
      ofmem[in_data_i.channel_index[IdxW-1:0]] <= in_data_i.offset_word;
    end
    scmem_q <= scmem[rd_addr];
    ofmem_q <= ofmem[rd_addr];
  end

  // table entries never loaded read as 1.0 and 0
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tvld_q    <= '0;
      tvld_rd_q <= 1'b0;
    end else begin
      if (ld_acc && ({1'b0, in_data_i.channel_index} < MaxCh))
        tvld_q[in_data_i.channel_index[IdxW-1:0]] <= 1'b1;
      tvld_rd_q <= tvld_q[rd_addr];
    end
  end

  // shared divide / root unit operands
  always_comb begin
    iu_req.start   = launch_q;
    iu_req.is_sqrt = state_q == S_SQRT;
    iu_opa         = '0;
    iu_opb         = {10'd0, n_act};
    unique case (state_q)
      S_MEAN: iu_opa = {16'd0, sum_abs};
      S_VDIV: iu_opa = sq_q;
      S_SQRT: iu_opa = {rad_q, 4'b0000};
      S_INV: begin
        iu_opa = 38'd1 << 24;
        iu_opb = s_q;
      end
      default: iu_opa = '0;
    endcase
  end

  ppln_iter u_iter (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (iu_req),
    .opa_i  (iu_opa),
    .opb_i  (iu_opb),
    .done_o (iu_done),
    .res_o  (iu_res)
  );

  // datapath helpers
  always_comb begin
    d   = {{2{smem_q[15]}}, smem_q} - {mean_q[16], mean_q};
    dd  = d * d;
    mag = iu_res[16:0];
    v   = 33'(signed'(p2_q[43:12])) + 33'(of_q);
    if (v > 33'sd32767) sat = 16'sh7fff;
    else if (v < -33'sd32768) sat = -16'sh8000;
    else sat = v[15:0];
  end

  // sequencer
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: if (smp_acc && pix_done) state_d = S_SUM;
      S_SUM:  if (idx_q >= n_act && !rv_q) state_d = S_MEAN;
      S_MEAN: if (iu_done) state_d = S_VAR;
      S_VAR:  if (idx_q >= n_act && !rv_q && !sv_q) state_d = S_VDIV;
      S_VDIV: if (iu_done) state_d = S_SQRT;
      S_SQRT: if (iu_done) state_d = S_INV;
      S_INV:  if (iu_done) state_d = S_OUT;
      S_OUT: begin
        if (ph_q == 2'd3 && (!out_valid_q || out_ready_i) && idx_q == n_act - 7'd1)
          state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cc_q        <= 7'd64;
      eps_q       <= 16'd1;
      fill_q      <= '0;
      idx_q       <= '0;
      ph_q        <= '0;
      rv_q        <= 1'b0;
      sv_q        <= 1'b0;
      launch_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      rv_q     <= issue && state_q != S_OUT;
      sv_q     <= rv_q && state_q == S_VAR;
      // start the shared unit on entry to each of its states
      launch_q <= (state_d != state_q) && (state_d == S_MEAN || state_d == S_VDIV ||
                  state_d == S_SQRT || state_d == S_INV);

      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          CFG_CHAN_NUM: begin
            cc_q   <= cfg_wdata_i[6:0];
            fill_q <= '0;
          end
          CFG_EPSILON: eps_q <= cfg_wdata_i;
          default: eps_q <= eps_q;
        endcase
      end else if (smp_acc) begin
        fill_q <= (pix_done || fill_q >= n_act) ? 7'd0 : fill_q + 7'd1;
      end

      if (state_d != state_q) idx_q <= '0;
      else if (issue && state_q != S_OUT) idx_q <= idx_q + 7'd1;

      if (out_valid_q && out_ready_i) out_valid_q <= 1'b0;

      if (state_q == S_OUT) begin
        if (ph_q != 2'd3) ph_q <= ph_q + 2'd1;
        else if (!out_valid_q || out_ready_i) begin
          out_valid_q <= 1'b1;
          ph_q        <= 2'd0;
          idx_q       <= idx_q + 7'd1;
        end
      end else begin
        ph_q <= 2'd0;
      end
    end
  end

  // arithmetic registers
  always_ff @(posedge clk_i) begin
    if (state_q == S_IDLE) begin
      sum_q <= '0;
      sq_q  <= '0;
    end
    if (state_q == S_SUM && rv_q) sum_q <= sum_q + 22'(signed'(smem_q));
    if (state_q == S_MEAN && iu_done)
      mean_q <= sum_q[21] ? -signed'(mag) : signed'(mag);
    if (rv_q) prod_q <= dd[31:0];
    if (sv_q) sq_q <= sq_q + {6'd0, prod_q};
    if (state_q == S_VDIV && iu_done) rad_q <= 34'(iu_res[31:0]) + 34'(eps_q);
    // a zero root takes the reciprocal of one
    if (state_q == S_SQRT && iu_done) s_q <= (iu_res[16:0] == '0) ? 17'd1 : iu_res[16:0];
    if (state_q == S_INV && iu_done) inv_q <= iu_res[24:0];
    if (state_q == S_OUT && ph_q == 2'd1) begin
      p1_q <= d * signed'({1'b0, inv_q});
      sc_q <= tvld_rd_q ? signed'(scmem_q) : 16'sd4096;
      of_q <= tvld_rd_q ? signed'(ofmem_q) : 16'sd0;
    end
    if (state_q == S_OUT && ph_q == 2'd2) p2_q <= signed'(p1_q[43:16]) * sc_q;
    if (state_q == S_OUT && ph_q == 2'd3 && (!out_valid_q || out_ready_i)) begin
      out_q.norm_value    <= sat;
      out_q.last_of_pixel <= idx_q == n_act - 7'd1;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

`ifndef SYNTHESIS
  a_iu_done_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    iu_done |-> (state_q == S_MEAN || state_q == S_VDIV || state_q == S_SQRT ||
                 state_q == S_INV))
    else $error("shared unit finished outside its states");

  a_fill_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_IDLE && cc_q != 7'd0 |-> fill_q < n_act)
    else $error("fill count beyond channel count");

  a_inv_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_OUT |-> inv_q != '0)
    else $error("zero reciprocal in output pass");
`endif

endmodule
